FILE: hdl/pcfc_pkg.sv
`default_nettype none
package pcfc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Register field widths are fixed by the register map.
   localparam int CFG_SIZE_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int PORT_W     = 16;
   localparam int BYTE_W     = 8;

   localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
   localparam int BPL_W    = $clog2(2 * MAX_WIDTH + 1);

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_GRAYSCALE_MODE = 2'd2,
      CSR_SWAP_BYTES     = 2'd3
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_VS_HIGH   = 6'b000010,
      PH_VS_LOW    = 6'b000100,
      PH_HREF_HIGH = 6'b001000,
      PH_BYTES     = 6'b010000,
      PH_HREF_LOW  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              end_of_line;
      logic              end_of_frame;
      logic              last;
   } rsp_word_type;

   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_SIZE_W-1:0] v);
      logic [WIDTH_W-1:0] r;
      if (v == '0) begin
         r = WIDTH_W'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         r = WIDTH_W'(MAX_WIDTH);
      end else begin
         r = WIDTH_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_SIZE_W-1:0] v);
      logic [HEIGHT_W-1:0] r;
      if (v == '0) begin
         r = HEIGHT_W'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         r = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         r = HEIGHT_W'(v);
      end
      return r;
   endfunction

   // Data byte is the high port byte with D0 and D1 merged in from bits 3 and 2.
   function automatic logic [BYTE_W-1:0] remap_byte(input logic [PORT_W-1:0] p);
      return p[15:8] | {6'b000000, p[2], p[3]};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pcfc_req_if.sv
`default_nettype none
interface pcfc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic                         vsync_level;
   logic                         href_level;
   logic                         pclk_level;
   logic [pcfc_pkg::PORT_W-1:0]  port_bits;

   modport source (output valid, command, vsync_level, href_level, pclk_level, port_bits,
                   input ready);
   modport sink (input valid, command, vsync_level, href_level, pclk_level, port_bits,
                 output ready);
endinterface
`default_nettype wire

FILE: hdl/pcfc_rsp_if.sv
`default_nettype none
interface pcfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pcfc_pkg::BYTE_W-1:0]  pixel_byte;
   logic                         end_of_line;
   logic                         end_of_frame;
   logic                         last;

   modport source (output valid, pixel_byte, end_of_line, end_of_frame, last,
                   input ready);
   modport sink (input valid, pixel_byte, end_of_line, end_of_frame, last,
                 output ready);
endinterface
`default_nettype wire

FILE: hdl/pcfc_csr_if.sv
`default_nettype none
interface pcfc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pcfc_pkg::CSR_IDX_W-1:0]   index;
   logic [pcfc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/parallel_camera_frame_capture.sv
`default_nettype none
// Captures one frame from an oversampled parallel camera bus. Each req word is one
// sample of the vsync, href, pclk and data pins, or an arm command that copies the
// size and mode registers and starts waiting for a vsync pulse. One req word is
// taken per clock while req is ready; the frame state and the byte remap are
// resolved in the cycle the word is accepted and its results (none, one, or two in
// swap mode) go into a four-word output queue. req is ready while the queue has
// room for two words, so with rsp always ready a sample is taken every cycle; a
// stalled rsp side backs up through the queue after at most four pending words.
// Register writes are always accepted and take effect at the next arm command.
module parallel_camera_frame_capture (
   input  wire         clock,
   input  wire         reset,
   pcfc_req_if.sink    req_bus,
   pcfc_rsp_if.source  rsp_bus,
   pcfc_csr_if.sink    csr_bus
);

   // Configuration registers.
   logic [pcfc_pkg::CFG_SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic                            grayscale_ff, swap_ff;

   // Settings latched at arm time.
   logic [pcfc_pkg::WIDTH_W-1:0]  lat_w_ff, lat_w_in;
   logic [pcfc_pkg::HEIGHT_W-1:0] lat_h_ff, lat_h_in;
   logic                          lat_gray_ff, lat_gray_in;
   logic                          lat_swap_ff, lat_swap_in;

   // Frame state.
   pcfc_pkg::phase_type             phase_ff, phase_in;
   logic [pcfc_pkg::HEIGHT_W-1:0]   line_count_ff, line_count_in;
   logic [pcfc_pkg::BPL_W-1:0]      byte_count_ff, byte_count_in;
   logic                            wait_high_ff, wait_high_in;
   logic [pcfc_pkg::BYTE_W-1:0]     held_byte_ff, held_byte_in;
   logic                            held_valid_ff, held_valid_in;

   // Output queue.
   pcfc_pkg::rsp_word_type          queue_ff [pcfc_pkg::Q_DEPTH];
   logic [pcfc_pkg::Q_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [pcfc_pkg::Q_CNT_W-1:0]    count_ff, count_in;

   logic                    req_fire, rsp_fire;
   logic [1:0]              push_n;
   pcfc_pkg::rsp_word_type  word0, word1;

   logic [pcfc_pkg::BYTE_W-1:0]    cur_byte;
   logic [pcfc_pkg::BPL_W:0]       bpl, byte_p1, byte_p2;
   logic [pcfc_pkg::HEIGHT_W:0]    line_p1;
   logic                           line_end, frame_end, gray_eol;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (count_ff <= pcfc_pkg::Q_CNT_W'(pcfc_pkg::Q_DEPTH - 2));
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.pixel_byte   = queue_ff[rd_ptr_ff].pixel_byte;
   assign rsp_bus.end_of_line  = queue_ff[rd_ptr_ff].end_of_line;
   assign rsp_bus.end_of_frame = queue_ff[rd_ptr_ff].end_of_frame;
   assign rsp_bus.last         = queue_ff[rd_ptr_ff].last;
   assign rsp_fire             = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= pcfc_pkg::CFG_SIZE_W'(320);
         frame_height_ff <= pcfc_pkg::CFG_SIZE_W'(240);
         grayscale_ff    <= 1'b0;
         swap_ff         <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (pcfc_pkg::csr_index_type'(csr_bus.index))
            pcfc_pkg::CSR_FRAME_WIDTH:    frame_width_ff  <= csr_bus.data;
            pcfc_pkg::CSR_FRAME_HEIGHT:   frame_height_ff <= csr_bus.data;
            pcfc_pkg::CSR_GRAYSCALE_MODE: grayscale_ff    <= csr_bus.data[0];
            pcfc_pkg::CSR_SWAP_BYTES:     swap_ff         <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   assign cur_byte  = pcfc_pkg::remap_byte(req_bus.port_bits);
   assign bpl       = {1'b0, pcfc_pkg::BPL_W'({lat_w_ff, 1'b0})};
   assign byte_p1   = {1'b0, byte_count_ff} + 1'b1;
   assign byte_p2   = {1'b0, byte_count_ff} + 2'd2;
   assign line_p1   = {1'b0, line_count_ff} + 1'b1;
   assign line_end  = (byte_p1 >= bpl);
   assign frame_end = line_end && (line_p1 >= {1'b0, lat_h_ff});
   assign gray_eol  = (byte_p2 >= bpl);

   always_comb begin
      lat_w_in      = lat_w_ff;
      lat_h_in      = lat_h_ff;
      lat_gray_in   = lat_gray_ff;
      lat_swap_in   = lat_swap_ff;
      phase_in      = phase_ff;
      line_count_in = line_count_ff;
      byte_count_in = byte_count_ff;
      wait_high_in  = wait_high_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      push_n        = 2'd0;
      word0         = '{pixel_byte: cur_byte, end_of_line: line_end,
                        end_of_frame: frame_end, last: 1'b1};
      word1         = '{pixel_byte: (held_valid_ff ? held_byte_ff : '0),
                        end_of_line: line_end, end_of_frame: frame_end, last: 1'b1};

      if (req_fire) begin
         if (req_bus.command) begin
            lat_w_in      = pcfc_pkg::clamp_width(frame_width_ff);
            lat_h_in      = pcfc_pkg::clamp_height(frame_height_ff);
            lat_gray_in   = grayscale_ff;
            lat_swap_in   = swap_ff;
            phase_in      = pcfc_pkg::PH_VS_HIGH;
            line_count_in = '0;
            byte_count_in = '0;
            wait_high_in  = 1'b0;
            held_byte_in  = '0;
            held_valid_in = 1'b0;
         end else begin
            unique case (phase_ff)
               pcfc_pkg::PH_IDLE: ;
               pcfc_pkg::PH_VS_HIGH: begin
                  if (req_bus.vsync_level) begin
                     phase_in = pcfc_pkg::PH_VS_LOW;
                  end
               end
               pcfc_pkg::PH_VS_LOW: begin
                  if (!req_bus.vsync_level) begin
                     phase_in      = pcfc_pkg::PH_HREF_HIGH;
                     line_count_in = '0;
                  end
               end
               pcfc_pkg::PH_HREF_HIGH: begin
                  if (req_bus.href_level) begin
                     phase_in      = pcfc_pkg::PH_BYTES;
                     byte_count_in = '0;
                     wait_high_in  = 1'b0;
                  end
               end
               pcfc_pkg::PH_BYTES: begin
                  if (!wait_high_ff) begin
                     if (!req_bus.pclk_level) begin
                        wait_high_in = 1'b1;
                        if (lat_gray_ff) begin
                           if (!byte_count_ff[0]) begin
                              word0.end_of_line  = gray_eol;
                              word0.end_of_frame = gray_eol &&
                                                   (line_p1 >= {1'b0, lat_h_ff});
                              push_n = 2'd1;
                           end
                        end else if (lat_swap_ff) begin
                           // Even byte is held; the odd byte releases the pair reversed.
                           if (!byte_count_ff[0]) begin
                              held_byte_in  = cur_byte;
                              held_valid_in = 1'b1;
                           end else begin
                              word0.end_of_line  = 1'b0;
                              word0.end_of_frame = 1'b0;
                              word0.last         = 1'b0;
                              held_valid_in      = 1'b0;
                              push_n             = 2'd2;
                           end
                        end else begin
                           push_n = 2'd1;
                        end
                     end
                  end else if (req_bus.pclk_level) begin
                     wait_high_in  = 1'b0;
                     byte_count_in = byte_p1[pcfc_pkg::BPL_W-1:0];
                     if (byte_p1 >= bpl) begin
                        phase_in = pcfc_pkg::PH_HREF_LOW;
                     end
                  end
               end
               pcfc_pkg::PH_HREF_LOW: begin
                  if (!req_bus.href_level) begin
                     line_count_in = line_p1[pcfc_pkg::HEIGHT_W-1:0];
                     phase_in = (line_p1 >= {1'b0, lat_h_ff}) ? pcfc_pkg::PH_IDLE
                                                              : pcfc_pkg::PH_HREF_HIGH;
                  end
               end
               default: phase_in = pcfc_pkg::PH_IDLE;
            endcase
         end
      end
   end

   assign count_in = count_ff + pcfc_pkg::Q_CNT_W'(push_n) -
                     pcfc_pkg::Q_CNT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_w_ff      <= pcfc_pkg::clamp_width(pcfc_pkg::CFG_SIZE_W'(320));
         lat_h_ff      <= pcfc_pkg::clamp_height(pcfc_pkg::CFG_SIZE_W'(240));
         lat_gray_ff   <= 1'b0;
         lat_swap_ff   <= 1'b0;
         phase_ff      <= pcfc_pkg::PH_IDLE;
         line_count_ff <= '0;
         byte_count_ff <= '0;
         wait_high_ff  <= 1'b0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         lat_w_ff      <= lat_w_in;
         lat_h_ff      <= lat_h_in;
         lat_gray_ff   <= lat_gray_in;
         lat_swap_ff   <= lat_swap_in;
         phase_ff      <= phase_in;
         line_count_ff <= line_count_in;
         byte_count_ff <= byte_count_in;
         wait_high_ff  <= wait_high_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         wr_ptr_ff     <= wr_ptr_ff + pcfc_pkg::Q_PTR_W'(push_n);
         rd_ptr_ff     <= rd_ptr_ff + pcfc_pkg::Q_PTR_W'(rsp_fire);
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= word1;
      end
   end

endmodule
`default_nettype wire
